>>> rtl/lruwb_pkg.sv
// Shared types and constants for the LRU write-back cache tracker.
`default_nettype none

package lruwb_pkg;

  localparam int unsigned Lines     = 256;
  localparam int unsigned IdBits    = 16;
  localparam int unsigned CountBits = 32;
  localparam int unsigned DirtyBits = $clog2(Lines + 1);

  typedef logic [IdBits-1:0]    id_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [DirtyBits-1:0] dirty_cnt_t;

  localparam count_t CountMax = {CountBits{1'b1}};

  // Input transaction.
  typedef struct packed {
    logic [15:0] access_id;
    logic        is_write;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic        hit;
    logic        writeback;
    logic        evicted_valid;
    logic [15:0] evicted_id;
    logic [31:0] read_count;
    logic [31:0] write_count;
    logic [8:0]  dirty_lines;
  } rsp_t;

  // Token walking down the recency chain. tag/valid/dirty carry the line that
  // is being pushed one slot older; done marks that the walk has settled.
  typedef struct packed {
    logic tok;
    logic done;
    logic hit;
    logic hit_dirty;
    id_t  tag;
    logic valid;
    logic dirty;
  } token_t;

endpackage

`default_nettype wire

>>> rtl/lruwb_cell.sv
// One slot of the recency chain: holds a line, swaps it with the passing token.
`default_nettype none

module lruwb_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lruwb_pkg::id_t  id_i,
  input  wire logic            set_dirty_i,
  input  wire lruwb_pkg::token_t tok_i,
  output lruwb_pkg::token_t    tok_o
);
  import lruwb_pkg::*;

  id_t    tag_q, tag_d;
  logic   valid_q, valid_d;
  logic   dirty_q, dirty_d;
  token_t tok_q, tok_d;
  logic   match;

  assign match = valid_q && (tag_q == id_i);

  always_comb begin
    tok_d   = tok_i;
    tag_d   = tag_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    if (tok_i.tok && !tok_i.done) begin
      // a live token hands the slot its line; an unmatched valid line moves on
      tag_d   = tok_i.tag;
      valid_d = tok_i.valid;
      dirty_d = tok_i.dirty;
      if (match) begin
        tok_d.done      = 1'b1;
        tok_d.hit       = 1'b1;
        tok_d.hit_dirty = dirty_q;
      end else if (!valid_q) begin
        tok_d.done = 1'b1;
      end else begin
        tok_d.tag   = tag_q;
        tok_d.valid = valid_q;
        tok_d.dirty = dirty_q;
      end
    end
    if (set_dirty_i) begin
      dirty_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

>>> rtl/lru_writeback_cache_tracker.sv
// Top level of the fully associative LRU write-back cache tracker.
`default_nettype none

// Tracks a fully associative write-back cache of 256 lines with LRU
// replacement. Lines sit in a chain of cells ordered by recency, youngest
// first. A transaction is accepted on start_i while busy_o is low; the new line
// enters the youngest cell and a token walks one cell per cycle toward the
// oldest, pushing each line one slot older until it reaches the matching line
// (hit), an empty slot, or falls off the end (eviction). The walk always
// covers the whole chain, so a new transaction is not accepted until the
// token has left the oldest cell, and busy_o is already low when the result
// strobe valid_o rises.
// The result is shown for exactly one cycle; the receiver cannot stall it.
// Miss and writeback counts saturate at all ones; dirty_lines counts resident
// dirty lines. A hit on a dirty line written again does not change the count.
module lru_writeback_cache_tracker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire lruwb_pkg::req_t in_i,
  output logic                 busy_o,
  output logic                 valid_o,
  output lruwb_pkg::rsp_t      result_o
);
  import lruwb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e     state_q;
  logic       inj_q;
  id_t        id_q;
  logic       wr_q;
  count_t     miss_cnt_q, miss_cnt_d;
  count_t     wb_cnt_q, wb_cnt_d;
  dirty_cnt_t dirty_cnt_q, dirty_cnt_d;
  logic       valid_q;
  rsp_t       rsp_q, rsp_d;

  token_t     chain [Lines+1];
  logic       accept;
  logic       finish;
  logic       fin_hit;
  logic       fin_evict;
  logic       fin_wb;
  logic       set_dirty;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // token entering the youngest cell carries the new line
  assign chain[0] = '{tok: inj_q, done: 1'b0, hit: 1'b0, hit_dirty: 1'b0,
                      tag: id_q, valid: 1'b1, dirty: wr_q};

  for (genvar k = 0; k < Lines; k++) begin : g_cell
    logic cell_set_dirty;
    if (k == 0) begin : g_first
      assign cell_set_dirty = set_dirty;
    end else begin : g_rest
      assign cell_set_dirty = 1'b0;
    end
    lruwb_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .id_i        (id_q),
      .set_dirty_i (cell_set_dirty),
      .tok_i       (chain[k]),
      .tok_o       (chain[k+1])
    );
  end

  // Token leaving the oldest cell closes the transaction.
  assign finish    = (state_q == ST_WALK) && chain[Lines].tok;
  assign fin_hit   = chain[Lines].done && chain[Lines].hit;
  assign fin_evict = !chain[Lines].done && chain[Lines].valid;
  assign fin_wb    = fin_evict && chain[Lines].dirty;
  // a hit keeps an existing dirty mark on the line now in the youngest slot
  assign set_dirty = finish && fin_hit && chain[Lines].hit_dirty;

  always_comb begin
    miss_cnt_d  = miss_cnt_q;
    wb_cnt_d    = wb_cnt_q;
    dirty_cnt_d = dirty_cnt_q;
    if (fin_hit) begin
      if (wr_q && !chain[Lines].hit_dirty) begin
        dirty_cnt_d = dirty_cnt_q + 1'b1;
      end
    end else begin
      if (miss_cnt_q != CountMax) begin
        miss_cnt_d = miss_cnt_q + 1'b1;
      end
      if (fin_wb) begin
        if (wb_cnt_q != CountMax) begin
          wb_cnt_d = wb_cnt_q + 1'b1;
        end
        dirty_cnt_d = dirty_cnt_d - 1'b1;
      end
      if (wr_q) begin
        dirty_cnt_d = dirty_cnt_d + 1'b1;
      end
    end

    rsp_d               = '0;
    rsp_d.hit           = fin_hit;
    rsp_d.writeback     = fin_wb;
    rsp_d.evicted_valid = fin_evict;
    rsp_d.evicted_id    = fin_evict ? 16'(chain[Lines].tag) : 16'd0;
    rsp_d.read_count    = 32'(miss_cnt_d);
    rsp_d.write_count   = 32'(wb_cnt_d);
    rsp_d.dirty_lines   = 9'(dirty_cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      inj_q       <= 1'b0;
      valid_q     <= 1'b0;
      miss_cnt_q  <= '0;
      wb_cnt_q    <= '0;
      dirty_cnt_q <= '0;
    end else begin
      inj_q   <= 1'b0;
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            inj_q   <= 1'b1;
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (finish) begin
            valid_q     <= 1'b1;
            miss_cnt_q  <= miss_cnt_d;
            wb_cnt_q    <= wb_cnt_d;
            dirty_cnt_q <= dirty_cnt_d;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q <= id_t'(in_i.access_id);
      wr_q <= in_i.is_write;
    end
    if (finish) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = rsp_q;

`ifndef SYNTHESIS
  a_no_start_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o && !valid_o)
    else $error("transaction accepted without going busy");

  a_result_frees_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o && $past(busy_o))
    else $error("result strobe outside end of a walk");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.hit) |-> (!result_o.writeback && !result_o.evicted_valid))
    else $error("hit reported with eviction");

  a_wb_needs_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.writeback) |-> result_o.evicted_valid)
    else $error("writeback without evicted line");

  a_dirty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.dirty_lines <= 9'(Lines)))
    else $error("dirty line count exceeds cache size");
`endif

endmodule

`default_nettype wire
